@@ rtl/ffra_pkg.sv @@
package ffra_pkg;

  localparam int unsigned MaxAllocsDefault = 64;
  localparam int unsigned PageBytesDefault = 4096;

  localparam logic [31:0] ResetBase = 32'h7380_0000;
  localparam logic [31:0] ResetSize = 32'h0880_0000;

  typedef enum logic [0:0] {
    REG_BASE = 1'b0,
    REG_SIZE = 1'b1
  } reg_index_t;

  typedef enum logic [1:0] {
    FUNC_ALLOC   = 2'd0,
    FUNC_FREE    = 2'd1,
    FUNC_RELEASE = 2'd2,
    FUNC_LOOKUP  = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_SIZE  = 3'd1,
    ST_NO_MEM    = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_NOT_OWNER = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN,
    S_SHUP_RD,
    S_SHUP,
    S_INSERT,
    S_SHDN_RD,
    S_SHDN,
    S_REL_RD,
    S_REL,
    S_DONE
  } state_t;

  // one table row: start, length, owner
  localparam int unsigned EntryW = 72;

endpackage

@@ rtl/ffra_ram.sv @@
module ffra_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/first_fit_region_allocator_core.sv @@
// First-fit region allocator. The allocation table (start, length, owner) sits in one
// single-port-write, registered-read RAM of MAX_ALLOCS rows kept sorted by start.
// A command walks the table row by row: one state issues the read, the next
// evaluates the registered data. Allocate scans up to the first fitting gap, then
// shifts the rows above it up and inserts the new row; free and lookup scan to the
// matching row, and free then shifts the upper rows down; release compacts the whole
// table in one pass. The result is held in an output register until taken; the next
// command is accepted once the result has been delivered. No reset sweep.
module first_fit_region_allocator_core #(
  parameter int unsigned MAX_ALLOCS = ffra_pkg::MaxAllocsDefault,
  parameter int unsigned PAGE_BYTES = ffra_pkg::PageBytesDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  func,
  input  logic [7:0]  owner_id,
  input  logic [31:0] request_size,
  input  logic [31:0] address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] granted_address,
  output logic [31:0] found_size
);

  localparam int unsigned AW = $clog2(MAX_ALLOCS);
  localparam int unsigned CW = $clog2(MAX_ALLOCS + 1);
  localparam int unsigned EW = ffra_pkg::EntryW;
  localparam logic [CW-1:0] CntMax = CW'(MAX_ALLOCS);

  logic [31:0] region_base, region_size;
  logic [CW-1:0] entry_count, entry_count_next;
  ffra_pkg::state_t state, state_next;

  // latched command
  logic [1:0]  cmd_func;
  logic [7:0]  cmd_owner;
  logic [31:0] cmd_addr;
  logic [32:0] cmd_len;
  logic [32:0] hole, hole_next;
  logic [CW-1:0] idx, idx_next;   // read pointer
  logic [CW-1:0] wptr, wptr_next; // write pointer (release compaction / shifts)
  logic [CW-1:0] pos, pos_next;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;

  logic [2:0]  res_status, res_status_next;
  logic [31:0] res_grant, res_grant_next, res_found, res_found_next;

  ffra_ram #(.WIDTH(EW), .DEPTH(MAX_ALLOCS)) u_table (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic [31:0] r_start, r_len;
  logic [7:0]  r_owner;
  assign r_start = rdata[71:40];
  assign r_len   = rdata[39:8];
  assign r_owner = rdata[7:0];

  // page rounding
  logic [32:0] req_round;
  always_comb begin
    logic [32:0] sum;
    sum = {1'b0, request_size} + 33'(PAGE_BYTES - 1);
    req_round = (sum / PAGE_BYTES) * PAGE_BYTES;
  end

  logic [32:0] limit;
  always_comb begin
    logic [32:0] l;
    l = {1'b0, region_base} + {1'b0, region_size};
    limit = (l > 33'h1_0000_0000) ? 33'h1_0000_0000 : l;
  end

  logic [32:0] r_end;
  assign r_end = {1'b0, r_start} + {1'b0, r_len};

  always_ff @(posedge clk) begin
    if (rst) begin
      region_base <= ffra_pkg::ResetBase;
      region_size <= ffra_pkg::ResetSize;
    end else if (cfg_we) begin
      unique case (ffra_pkg::reg_index_t'(cfg_index))
        ffra_pkg::REG_BASE: region_base <= cfg_data;
        ffra_pkg::REG_SIZE: region_size <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ffra_pkg::S_IDLE;
      entry_count <= '0;
    end else begin
      state       <= state_next;
      entry_count <= entry_count_next;
    end
  end

  always_ff @(posedge clk) begin
    hole       <= hole_next;
    idx        <= idx_next;
    wptr       <= wptr_next;
    pos        <= pos_next;
    res_status <= res_status_next;
    res_grant  <= res_grant_next;
    res_found  <= res_found_next;
    if (in_valid && in_ready) begin
      cmd_func  <= func;
      cmd_owner <= owner_id;
      cmd_addr  <= address;
      cmd_len   <= req_round;
    end
  end

  assign in_ready        = (state == ffra_pkg::S_IDLE);
  assign out_valid       = (state == ffra_pkg::S_DONE);
  assign status          = res_status;
  assign granted_address = res_grant;
  assign found_size      = res_found;

  always_comb begin
    state_next       = state;
    entry_count_next = entry_count;
    hole_next        = hole;
    idx_next         = idx;
    wptr_next        = wptr;
    pos_next         = pos;
    res_status_next  = res_status;
    res_grant_next   = res_grant;
    res_found_next   = res_found;
    we    = 1'b0;
    waddr = wptr[AW-1:0];
    wdata = rdata;
    raddr = idx[AW-1:0];

    unique case (state)
      ffra_pkg::S_IDLE: begin
        if (in_valid) begin
          res_status_next = ffra_pkg::ST_OK;
          res_grant_next  = '0;
          res_found_next  = '0;
          hole_next       = {1'b0, region_base};
          idx_next        = '0;
          wptr_next       = '0;
          raddr           = '0;
          unique case (ffra_pkg::func_t'(func))
            ffra_pkg::FUNC_ALLOC: begin
              if (req_round == '0 || req_round > {1'b0, region_size}) begin
                res_status_next = ffra_pkg::ST_BAD_SIZE;
                state_next = ffra_pkg::S_DONE;
              end else if (entry_count >= CntMax) begin
                res_status_next = ffra_pkg::ST_NO_MEM;
                state_next = ffra_pkg::S_DONE;
              end else begin
                state_next = ffra_pkg::S_SCAN_RD;
              end
            end
            ffra_pkg::FUNC_RELEASE: state_next = ffra_pkg::S_REL_RD;
            default: state_next = ffra_pkg::S_SCAN_RD;
          endcase
        end
      end

      ffra_pkg::S_SCAN_RD: begin
        if (idx >= entry_count) begin
          if (cmd_func == ffra_pkg::FUNC_ALLOC) begin
            pos_next = entry_count;
            state_next = ffra_pkg::S_INSERT;
            if (hole > limit || limit - hole < cmd_len) begin
              res_status_next = ffra_pkg::ST_NO_MEM;
              state_next = ffra_pkg::S_DONE;
            end
          end else begin
            res_status_next = ffra_pkg::ST_NOT_FOUND;
            state_next = ffra_pkg::S_DONE;
          end
        end else begin
          state_next = ffra_pkg::S_SCAN;
        end
      end

      ffra_pkg::S_SCAN: begin
        idx_next   = idx + 1'b1;
        raddr      = AW'(idx + 1'b1);
        state_next = ffra_pkg::S_SCAN_RD;
        if (cmd_func == ffra_pkg::FUNC_ALLOC) begin
          if ({1'b0, r_start} >= hole && {1'b0, r_start} - hole >= cmd_len) begin
            // fitting gap ahead of this row; it is the insertion point
            pos_next = idx;
            if (hole > limit || limit - hole < cmd_len) begin
              res_status_next = ffra_pkg::ST_NO_MEM;
              state_next = ffra_pkg::S_DONE;
            end else begin
              wptr_next  = entry_count;
              idx_next   = entry_count - 1'b1;
              state_next = ffra_pkg::S_SHUP_RD;
            end
          end else if (r_end > hole) begin
            hole_next = r_end;
          end
        end else if (r_start == cmd_addr) begin
          if (cmd_func == ffra_pkg::FUNC_LOOKUP) begin
            res_found_next = r_len;
            state_next = ffra_pkg::S_DONE;
          end else if (r_owner != cmd_owner) begin
            res_status_next = ffra_pkg::ST_NOT_OWNER;
            state_next = ffra_pkg::S_DONE;
          end else begin
            wptr_next  = idx;
            idx_next   = idx + 1'b1;
            state_next = ffra_pkg::S_SHDN_RD;
          end
        end
      end

      // shift rows [pos, count) up by one, top first
      ffra_pkg::S_SHUP_RD: begin
        if (wptr == pos) state_next = ffra_pkg::S_INSERT;
        else state_next = ffra_pkg::S_SHUP;
      end
      ffra_pkg::S_SHUP: begin
        we         = 1'b1;
        wptr_next  = wptr - 1'b1;
        idx_next   = idx - 1'b1;
        raddr      = AW'(idx - 1'b1);
        state_next = ffra_pkg::S_SHUP_RD;
      end
      ffra_pkg::S_INSERT: begin
        we    = 1'b1;
        waddr = pos[AW-1:0];
        wdata = {hole[31:0], cmd_len[31:0], cmd_owner};
        res_grant_next   = hole[31:0];
        entry_count_next = entry_count + 1'b1;
        state_next       = ffra_pkg::S_DONE;
      end

      // shift rows above the freed one down by one
      ffra_pkg::S_SHDN_RD: begin
        if (idx >= entry_count) begin
          entry_count_next = entry_count - 1'b1;
          state_next = ffra_pkg::S_DONE;
        end else begin
          state_next = ffra_pkg::S_SHDN;
        end
      end
      ffra_pkg::S_SHDN: begin
        we         = 1'b1;
        wptr_next  = wptr + 1'b1;
        idx_next   = idx + 1'b1;
        raddr      = AW'(idx + 1'b1);
        state_next = ffra_pkg::S_SHDN_RD;
      end

      // release: one compaction pass, keep rows of other owners
      ffra_pkg::S_REL_RD: begin
        if (idx >= entry_count) begin
          entry_count_next = wptr;
          state_next = ffra_pkg::S_DONE;
        end else begin
          state_next = ffra_pkg::S_REL;
        end
      end
      ffra_pkg::S_REL: begin
        if (r_owner != cmd_owner) begin
          we        = 1'b1;
          wptr_next = wptr + 1'b1;
        end
        idx_next   = idx + 1'b1;
        raddr      = AW'(idx + 1'b1);
        state_next = ffra_pkg::S_REL_RD;
      end

      ffra_pkg::S_DONE: begin
        if (out_ready) state_next = ffra_pkg::S_IDLE;
      end

      default: state_next = ffra_pkg::S_IDLE;
    endcase
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CntMax)
    else $error("entry count above table depth");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    state == ffra_pkg::S_INSERT |=> entry_count == $past(entry_count) + 1'b1)
    else $error("insert did not grow the table");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    we |-> waddr <= AW'(entry_count) || entry_count == CntMax)
    else $error("table write beyond fill");

  a_ok_grant: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ffra_pkg::ST_OK |-> granted_address == '0 && found_size == '0)
    else $error("result fields set on failure");

endmodule

@@ tb/first_fit_region_allocator_core_test.sv @@
module first_fit_region_allocator_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS = ffra_pkg::MaxAllocsDefault;
  localparam int unsigned PAGE = ffra_pkg::PageBytesDefault;

  typedef struct packed {
    ffra_pkg::status_t status;
    logic [31:0]       granted;
    logic [31:0]       found;
  } alloc_result_t;

  // Table-level model of the allocator; expected results queue up per command.
  class alloc_scoreboard;
    logic [31:0]   base, span;
    logic [31:0]   tbl_start[SLOTS];
    logic [31:0]   tbl_len[SLOTS];
    logic [7:0]    tbl_owner[SLOTS];
    int            used;
    alloc_result_t pending[$];
    int            errors;

    function new();
      base = ffra_pkg::ResetBase;
      span = ffra_pkg::ResetSize;
      used = 0;
      errors = 0;
    endfunction

    function void set_reg(ffra_pkg::reg_index_t idx, logic [31:0] v);
      if (idx == ffra_pkg::REG_BASE) base = v;
      else span = v;
    endfunction

    function void remove_row(int idx);
      for (int i = idx; i + 1 < used; i++) begin
        tbl_start[i] = tbl_start[i+1];
        tbl_len[i] = tbl_len[i+1];
        tbl_owner[i] = tbl_owner[i+1];
      end
      used--;
    endfunction

    function alloc_result_t allocate(logic [7:0] own, logic [31:0] req);
      alloc_result_t r;
      logic [63:0] len, hole, lim, s, e;
      int pos;
      r = '{ffra_pkg::ST_OK, 32'd0, 32'd0};
      len = ((64'(req) + PAGE - 1) / PAGE) * PAGE;
      hole = 64'(base);
      lim = 64'(base) + 64'(span);
      if (len == 0 || len > 64'(span)) begin
        r.status = ffra_pkg::ST_BAD_SIZE;
        return r;
      end
      if (used >= SLOTS) begin
        r.status = ffra_pkg::ST_NO_MEM;
        return r;
      end
      if (lim > 64'h1_0000_0000) lim = 64'h1_0000_0000;
      for (int i = 0; i < used; i++) begin
        s = 64'(tbl_start[i]);
        e = s + 64'(tbl_len[i]);
        if (s >= hole && s - hole >= len) break;
        if (e > hole) hole = e;
      end
      if (hole > lim || lim - hole < len) begin
        r.status = ffra_pkg::ST_NO_MEM;
        return r;
      end
      pos = used;
      for (int i = 0; i < used; i++)
        if (64'(tbl_start[i]) > hole) begin
          pos = i;
          break;
        end
      for (int i = used; i > pos; i--) begin
        tbl_start[i] = tbl_start[i-1];
        tbl_len[i] = tbl_len[i-1];
        tbl_owner[i] = tbl_owner[i-1];
      end
      tbl_start[pos] = hole[31:0];
      tbl_len[pos] = len[31:0];
      tbl_owner[pos] = own;
      used++;
      r.granted = hole[31:0];
      return r;
    endfunction

    function int find_row(logic [31:0] a);
      for (int i = 0; i < used; i++)
        if (tbl_start[i] == a) return i;
      return -1;
    endfunction

    function void note_command(ffra_pkg::func_t f, logic [7:0] own, logic [31:0] req,
                               logic [31:0] a);
      alloc_result_t r;
      int idx;
      r = '{ffra_pkg::ST_OK, 32'd0, 32'd0};
      case (f)
        ffra_pkg::FUNC_ALLOC: r = allocate(own, req);
        ffra_pkg::FUNC_FREE: begin
          idx = find_row(a);
          if (idx < 0) r.status = ffra_pkg::ST_NOT_FOUND;
          else if (tbl_owner[idx] != own) r.status = ffra_pkg::ST_NOT_OWNER;
          else remove_row(idx);
        end
        ffra_pkg::FUNC_RELEASE: begin
          idx = 0;
          while (idx < used) begin
            if (tbl_owner[idx] == own) remove_row(idx);
            else idx++;
          end
        end
        default: begin
          idx = find_row(a);
          if (idx < 0) r.status = ffra_pkg::ST_NOT_FOUND;
          else r.found = tbl_len[idx];
        end
      endcase
      pending.push_back(r);
    endfunction

    function void check_result(logic [2:0] st, logic [31:0] g, logic [31:0] fs);
      alloc_result_t x;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: status %0d", st);
        return;
      end
      x = pending.pop_front();
      if (st !== x.status || g !== x.granted || fs !== x.found) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: exp st %0d ga %h fs %h, got st %0d ga %h fs %h",
                   x.status, x.granted, x.found, st, g, fs);
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid, in_ready;
  logic [1:0]  func;
  logic [7:0]  owner_id;
  logic [31:0] request_size, address;
  logic        out_valid, out_ready;
  logic [2:0]  status;
  logic [31:0] granted_address, found_size;

  alloc_scoreboard board;
  int  send_idle_pct, recv_idle_pct;
  int  hold_cycles;
  logic [31:0] granted_log[$];

  first_fit_region_allocator_core DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .func(func), .owner_id(owner_id),
    .request_size(request_size), .address(address), .out_valid(out_valid),
    .out_ready(out_ready), .status(status), .granted_address(granted_address),
    .found_size(found_size)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("Some tests failed");
    $finish;
  end

  // receiver: random stalls, plus an optional long hold-off
  always @(negedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      board.check_result(status, granted_address, found_size);
      if (status == ffra_pkg::ST_OK && granted_address != 0)
        granted_log.push_back(granted_address);
    end
  end

  task automatic write_reg(ffra_pkg::reg_index_t idx, logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    board.set_reg(idx, v);
  endtask

  // valid stays up after the transaction until the next call or drain() drops it
  task automatic send_command(ffra_pkg::func_t f, logic [7:0] own, logic [31:0] req,
                              logic [31:0] a);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    func <= f;
    owner_id <= own;
    request_size <= req;
    address <= a;
    do @(posedge clk); while (!in_ready);
    board.note_command(f, own, req, a);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (250) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_address();
    int r;
    r = $urandom_range(9);
    if (r < 6 && granted_log.size() > 0)
      return granted_log[$urandom_range(granted_log.size() - 1)];
    if (r < 8) return board.base + PAGE * $urandom_range(64);
    return $urandom();
  endfunction

  function automatic logic [31:0] pick_size();
    case ($urandom_range(9))
      0: return $urandom();
      1: return 32'd0;
      2: return PAGE * $urandom_range(1, 4);
      3: return board.span + $urandom_range(0, PAGE);
      default: return $urandom_range(1, 6 * PAGE);
    endcase
  endfunction

  task automatic random_phase(int count);
    int   r;
    ffra_pkg::func_t f;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 50) f = ffra_pkg::FUNC_ALLOC;
      else if (r < 75) f = ffra_pkg::FUNC_FREE;
      else if (r < 82) f = ffra_pkg::FUNC_RELEASE;
      else f = ffra_pkg::FUNC_LOOKUP;
      send_command(f, 8'($urandom_range(7)) | (($urandom_range(9) == 0) ? 8'($urandom()) : 8'h0),
                   pick_size(), pick_address());
    end
  endtask

  initial begin
    board = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    func = '0;
    owner_id = '0;
    request_size = '0;
    address = '0;
    hold_cycles = 0;
    send_idle_pct = 34;
    recv_idle_pct = 75;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset window, size edges, every function, owner checks
    send_command(ffra_pkg::FUNC_ALLOC, 8'h01, 32'd0, 32'd0);
    send_command(ffra_pkg::FUNC_ALLOC, 8'h01, 32'd1, 32'd0);
    send_command(ffra_pkg::FUNC_ALLOC, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(ffra_pkg::FUNC_ALLOC, 8'h02, ffra_pkg::ResetSize + 1, 32'd0);
    send_command(ffra_pkg::FUNC_ALLOC, 8'h02, 32'd8192, 32'd0);
    send_command(ffra_pkg::FUNC_LOOKUP, 8'h00, 32'd0, ffra_pkg::ResetBase);
    send_command(ffra_pkg::FUNC_LOOKUP, 8'h00, 32'd0, ffra_pkg::ResetBase + 1);
    send_command(ffra_pkg::FUNC_FREE, 8'h02, 32'd0, ffra_pkg::ResetBase);
    send_command(ffra_pkg::FUNC_FREE, 8'h01, 32'd0, ffra_pkg::ResetBase);
    send_command(ffra_pkg::FUNC_ALLOC, 8'h03, 32'd4097, 32'd0);
    send_command(ffra_pkg::FUNC_FREE, 8'h01, 32'd0, 32'hFFFF_FFFF);
    send_command(ffra_pkg::FUNC_RELEASE, 8'h77, 32'd0, 32'd0);
    send_command(ffra_pkg::FUNC_RELEASE, 8'h02, 32'hFFFF_FFFF, 32'd0);
    send_command(ffra_pkg::FUNC_LOOKUP, 8'h00, 32'd0, ffra_pkg::ResetBase + PAGE);
    send_command(ffra_pkg::FUNC_ALLOC, 8'h00, ffra_pkg::ResetSize, 32'd0);
    send_command(ffra_pkg::FUNC_RELEASE, 8'h03, 32'd0, 32'd0);
    drain();

    // table full, with a long receiver stall on top
    write_reg(ffra_pkg::REG_SIZE, 32'h0010_0000);
    hold_cycles = 600;
    for (int i = 0; i < 66; i++) send_command(ffra_pkg::FUNC_ALLOC, 8'(i % 3), 32'd1, 32'd0);
    send_command(ffra_pkg::FUNC_RELEASE, 8'h00, 32'd0, 32'd0);
    send_command(ffra_pkg::FUNC_RELEASE, 8'h01, 32'd0, 32'd0);
    drain();

    // window crossing 2^32, entries left outside the moved window
    write_reg(ffra_pkg::REG_BASE, 32'hFFFF_0000);
    write_reg(ffra_pkg::REG_SIZE, 32'hFFFF_FFFF);
    random_phase(120);
    drain();
    write_reg(ffra_pkg::REG_BASE, 32'd0);
    write_reg(ffra_pkg::REG_SIZE, 32'h0004_0000);
    random_phase(230);
    drain();

    send_idle_pct = 75;
    recv_idle_pct = 34;
    write_reg(ffra_pkg::REG_BASE, 32'h0000_8000);
    write_reg(ffra_pkg::REG_SIZE, 32'h0003_0000);
    random_phase(250);
    drain();
    write_reg(ffra_pkg::REG_BASE, ffra_pkg::ResetBase);
    write_reg(ffra_pkg::REG_SIZE, 32'd0);
    random_phase(40);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(ffra_pkg::REG_SIZE, ffra_pkg::ResetSize);
    random_phase(300);
    drain();

    if (board.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

@@ files.f @@
rtl/ffra_pkg.sv
rtl/ffra_ram.sv
rtl/first_fit_region_allocator_core.sv
tb/first_fit_region_allocator_core_test.sv
